// File: hw/rtl/nnis_pkg.sv
// shared types and constants of the nearest-neighbor image scaler
`timescale 1ns / 1ps
package nnis_pkg;

  // operation codes of an input transaction
  localparam logic OP_PIXEL   = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // status codes of a result transaction
  localparam logic [2:0] ST_PIXEL    = 3'd0;
  localparam logic [2:0] ST_WAIT     = 3'd1;
  localparam logic [2:0] ST_DONE     = 3'd2;
  localparam logic [2:0] ST_STORED   = 3'd3;
  localparam logic [2:0] ST_SKIPPED  = 3'd4;
  localparam logic [2:0] ST_REJECTED = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SCALE_FACTOR  = 2'd2;

  localparam logic [12:0] HEIGHT_LIMIT = 13'd4096;
  localparam logic [14:0] FACTOR_LIMIT = 15'd25600;
  localparam logic [12:0] NO_ROW       = 13'h1FFF;

  typedef struct packed {
    logic       operation;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       last_in_row;
    logic       last_in_image;
    logic [1:0] pad_bytes;
  } out_t;

  // classified queue entry
  typedef struct packed {
    logic        is_request;
    logic [23:0] pixel;
  } item_t;

  // geometry worked out after each restart
  typedef struct packed {
    logic [12:0] eff_w;
    logic [12:0] eff_h;
    logic [18:0] dest_width;
    logic [18:0] dest_height;
    logic [31:0] col_step;
    logic [31:0] row_step;
  } geom_t;

endpackage

// File: hw/rtl/nearest_neighbor_image_scaler.sv
// top level of the nearest-neighbor image scaler
//
//  channel  direction  signals                              transaction when
//  in       input      in_valid_i, in_ready_o, in_data_i    valid and ready high
//  out      output     out_valid_o, out_ready_i, out_data_o valid and ready high
//  cfg      input      cfg_we_i, cfg_addr_i, cfg_wdata_i    write enable high
//
// the execution side handles an output pixel in an execute state and then a read state
// (line store read is registered); a two-entry queue separates input and execution
// after reset and after every register write, geometry setup runs the sizing steps
// and two 29-step ratio divisions on one shared divider; no input is taken meanwhile
// a result waits in the output register while further input transactions queue up
`timescale 1ns / 1ps
module nearest_neighbor_image_scaler #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  nnis_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output nnis_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_addr_i,
  input  logic [14:0]    cfg_wdata_i
);

  localparam logic [2:0] S_MUL   = 3'd0;
  localparam logic [2:0] S_SIZE  = 3'd1;
  localparam logic [2:0] S_WGO   = 3'd2;
  localparam logic [2:0] S_WWAIT = 3'd3;
  localparam logic [2:0] S_HGO   = 3'd4;
  localparam logic [2:0] S_HWAIT = 3'd5;
  localparam logic [2:0] S_RUN   = 3'd6;

  logic [12:0] sw_q, sh_q;
  logic [14:0] sf_q;
  logic [2:0]  setup_q, setup_d;
  logic        cfg_hit;

  logic [12:0] effw_c, effh_c;
  logic [14:0] f_c;
  logic [27:0] pw_q, ph_q;
  logic [27:0] pw_r, ph_r;
  logic [18:0] dw_c, dh_c;
  nnis_pkg::geom_t geom_q;

  logic        div_start;
  logic [28:0] div_num;
  logic [18:0] div_den;
  logic        div_done;
  logic [31:0] div_quo;

  logic            item_valid;
  nnis_pkg::item_t item;
  logic            item_pop;

  assign cfg_hit = cfg_we_i && (cfg_addr_i == nnis_pkg::REG_SOURCE_WIDTH
                   || cfg_addr_i == nnis_pkg::REG_SOURCE_HEIGHT
                   || cfg_addr_i == nnis_pkg::REG_SCALE_FACTOR);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= 13'd1;
      sh_q <= 13'd1;
      sf_q <= 15'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        nnis_pkg::REG_SOURCE_WIDTH:  sw_q <= cfg_wdata_i[12:0];
        nnis_pkg::REG_SOURCE_HEIGHT: sh_q <= cfg_wdata_i[12:0];
        nnis_pkg::REG_SCALE_FACTOR:  sf_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // clamped sizes and factor
  always_comb begin
    effw_c = (sw_q == '0) ? 13'd1 : sw_q;
    if ({19'b0, effw_c} > 32'(MAX_WIDTH)) effw_c = 13'(MAX_WIDTH);
    effh_c = (sh_q == '0) ? 13'd1 : sh_q;
    if (effh_c > nnis_pkg::HEIGHT_LIMIT) effh_c = nnis_pkg::HEIGHT_LIMIT;
    f_c = (sf_q > nnis_pkg::FACTOR_LIMIT) ? nnis_pkg::FACTOR_LIMIT : sf_q;
  end

  // destination sizes, half rounds down
  assign pw_r = pw_q + 28'd127;
  assign ph_r = ph_q + 28'd127;
  always_comb begin
    dw_c = pw_r[26:8];
    dh_c = ph_r[26:8];
    if (dw_c == '0 || dh_c == '0) begin
      dw_c = '0;
      dh_c = '0;
    end
  end

  // setup sequencer
  always_comb begin
    setup_d   = setup_q;
    div_start = 1'b0;
    div_num   = 29'({geom_q.eff_w, 16'h0}) + 29'(geom_q.dest_width) - 29'd1;
    div_den   = geom_q.dest_width;
    unique case (setup_q)
      S_MUL:   setup_d = S_SIZE;
      S_SIZE:  setup_d = S_WGO;
      S_WGO: begin
        div_start = 1'b1;
        setup_d   = S_WWAIT;
      end
      S_WWAIT: if (div_done) setup_d = S_HGO;
      S_HGO: begin
        div_start = 1'b1;
        div_num   = 29'({geom_q.eff_h, 16'h0}) + 29'(geom_q.dest_height) - 29'd1;
        div_den   = geom_q.dest_height;
        setup_d   = S_HWAIT;
      end
      S_HWAIT: if (div_done) setup_d = S_RUN;
      S_RUN:   setup_d = S_RUN;
      default: setup_d = S_MUL;
    endcase
    if (cfg_hit) setup_d = S_MUL;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) setup_q <= S_MUL;
    else         setup_q <= setup_d;
  end

  // geometry registers
  always_ff @(posedge clk_i) begin
    if (setup_q == S_MUL) begin
      pw_q <= 28'(effw_c) * 28'(f_c);
      ph_q <= 28'(effh_c) * 28'(f_c);
      geom_q.eff_w <= effw_c;
      geom_q.eff_h <= effh_c;
    end
    if (setup_q == S_SIZE) begin
      geom_q.dest_width  <= dw_c;
      geom_q.dest_height <= dh_c;
    end
    if (setup_q == S_WWAIT && div_done) geom_q.col_step <= div_quo;
    if (setup_q == S_HWAIT && div_done) geom_q.row_step <= div_quo;
  end

  nnis_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  nnis_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .enable_i     (setup_q == S_RUN),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  nnis_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .restart_i    (setup_q == S_MUL),
    .geom_i       (geom_q),
    .item_valid_i (item_valid && setup_q == S_RUN),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

// File: hw/rtl/nnis_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module nnis_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [28:0] num_i,
  input  logic [18:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o
);

  logic [28:0] quo_q, quo_d;
  logic [18:0] rem_q, rem_d;
  logic [18:0] den_q;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [19:0] trial;

  // one shift-subtract step
  always_comb begin
    trial  = {rem_q, quo_q[28]};
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = 19'(trial - {1'b0, den_q});
        quo_d = {quo_q[27:0], 1'b1};
      end else begin
        rem_d = trial[18:0];
        quo_d = {quo_q[27:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd28) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  // a zero divisor gives a zero ratio
  assign done_o = done_q;
  assign quo_o  = (den_q == '0) ? '0 : {3'b0, quo_q};

endmodule

// File: hw/rtl/nnis_front.sv
// input side: accepts and classifies transactions into a two-entry queue
`timescale 1ns / 1ps
module nnis_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           enable_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  nnis_pkg::in_t  in_data_i,
  output logic           item_valid_o,
  output nnis_pkg::item_t item_o,
  input  logic           item_pop_i
);

  nnis_pkg::item_t slots_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      count_q;
  logic            push;
  logic            pop;

  assign in_ready_o   = enable_i && (count_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (count_q != 2'd0);
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = slots_q[rd_ptr_q];

  // queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      count_q <= count_q + 2'd1;
      else if (pop && !push) count_q <= count_q - 2'd1;
    end
  end

  // classify and store
  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q].is_request <= (in_data_i.operation == nnis_pkg::OP_REQUEST);
      slots_q[wr_ptr_q].pixel      <= {in_data_i.red, in_data_i.green, in_data_i.blue};
    end
  end

endmodule

// File: hw/rtl/nnis_back.sv
// execution side: line store, row and column walk, result register
`timescale 1ns / 1ps
module nnis_back #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            restart_i,
  input  nnis_pkg::geom_t geom_i,
  input  logic            item_valid_i,
  input  nnis_pkg::item_t item_i,
  output logic            item_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output nnis_pkg::out_t  out_data_o
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam logic B_EXEC = 1'b0;
  localparam logic B_READ = 1'b1;

  logic [23:0] line_mem [MAX_WIDTH];
  logic [23:0] rdata_q;

  logic        bstate_q, bstate_d;
  logic [12:0] loaded_q, loaded_d;
  logic [12:0] irow_q, irow_d;
  logic [12:0] icol_q, icol_d;
  logic [18:0] drow_q, drow_d;
  logic [18:0] dcol_q, dcol_d;
  logic [31:0] cacc_q, cacc_d;
  logic [31:0] racc_q, racc_d;
  logic        out_valid_q, out_valid_d;
  nnis_pkg::out_t out_q, out_d;

  logic        fire;
  logic [12:0] need;
  logic [15:0] racc_hi, cacc_hi;
  logic [12:0] col_sel;
  logic        wr_en, rd_en;
  logic [AW+12:0] waddr_ext, raddr_ext;
  logic [1:0]  dw3;

  assign fire       = (bstate_q == B_EXEC) && item_valid_i && !restart_i
                      && (!out_valid_q || out_ready_i);
  assign item_pop_o = fire;
  assign racc_hi    = racc_q[31:16];
  assign cacc_hi    = cacc_q[31:16];
  assign dw3        = 2'(geom_i.dest_width[1:0] * 2'd3);
  assign waddr_ext  = {{AW{1'b0}}, icol_q};
  assign raddr_ext  = {{AW{1'b0}}, col_sel};

  // source row the current destination row needs
  always_comb begin
    if (drow_q >= geom_i.dest_height) need = geom_i.eff_h;
    else if (racc_hi > {3'b0, geom_i.eff_h - 13'd1}) need = geom_i.eff_h - 13'd1;
    else need = racc_hi[12:0];
    if (cacc_hi > {3'b0, geom_i.eff_w - 13'd1}) col_sel = geom_i.eff_w - 13'd1;
    else col_sel = cacc_hi[12:0];
  end

  // execute one transaction
  always_comb begin
    bstate_d    = bstate_q;
    loaded_d    = loaded_q;
    irow_d      = irow_q;
    icol_d      = icol_q;
    drow_d      = drow_q;
    dcol_d      = dcol_q;
    cacc_d      = cacc_q;
    racc_d      = racc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    if (bstate_q == B_READ) begin
      out_d.out_blue  = rdata_q[7:0];
      out_d.out_green = rdata_q[15:8];
      out_d.out_red   = rdata_q[23:16];
      out_valid_d     = 1'b1;
      bstate_d        = B_EXEC;
    end else if (fire) begin
      out_d = '0;
      if (!item_i.is_request) begin
        out_valid_d = 1'b1;
        if (irow_q >= geom_i.eff_h || irow_q > need) begin
          out_d.status = nnis_pkg::ST_REJECTED;
        end else begin
          if (irow_q == need) begin
            if (icol_q == '0) loaded_d = nnis_pkg::NO_ROW;
            wr_en        = 1'b1;
            out_d.status = nnis_pkg::ST_STORED;
          end else begin
            out_d.status = nnis_pkg::ST_SKIPPED;
          end
          icol_d = icol_q + 13'd1;
          if (icol_q + 13'd1 >= geom_i.eff_w) begin
            if (irow_q == need) loaded_d = irow_q;
            icol_d = '0;
            irow_d = irow_q + 13'd1;
          end
        end
      end else if (drow_q >= geom_i.dest_height) begin
        out_valid_d  = 1'b1;
        out_d.status = nnis_pkg::ST_DONE;
      end else if (loaded_q != need) begin
        out_valid_d  = 1'b1;
        out_d.status = nnis_pkg::ST_WAIT;
      end else begin
        rd_en        = 1'b1;
        bstate_d     = B_READ;
        out_d.status = nnis_pkg::ST_PIXEL;
        if (dcol_q + 19'd1 >= geom_i.dest_width) begin
          out_d.last_in_row   = 1'b1;
          out_d.last_in_image = (drow_q + 19'd1 >= geom_i.dest_height);
          out_d.pad_bytes     = 2'(2'd0 - dw3);
          dcol_d = '0;
          cacc_d = '0;
          drow_d = drow_q + 19'd1;
          racc_d = racc_q + geom_i.row_step;
        end else begin
          dcol_d = dcol_q + 19'd1;
          cacc_d = cacc_q + geom_i.col_step;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bstate_q    <= B_EXEC;
      loaded_q    <= nnis_pkg::NO_ROW;
      irow_q      <= '0;
      icol_q      <= '0;
      drow_q      <= '0;
      dcol_q      <= '0;
      cacc_q      <= '0;
      racc_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (restart_i) begin
      bstate_q    <= B_EXEC;
      loaded_q    <= nnis_pkg::NO_ROW;
      irow_q      <= '0;
      icol_q      <= '0;
      drow_q      <= '0;
      dcol_q      <= '0;
      cacc_q      <= '0;
      racc_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      bstate_q    <= bstate_d;
      loaded_q    <= loaded_d;
      irow_q      <= irow_d;
      icol_q      <= icol_d;
      drow_q      <= drow_d;
      dcol_q      <= dcol_d;
      cacc_q      <= cacc_d;
      racc_q      <= racc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // line store
  always_ff @(posedge clk_i) begin
    if (wr_en) line_mem[waddr_ext[AW-1:0]] <= item_i.pixel;
    if (rd_en) rdata_q <= line_mem[raddr_ext[AW-1:0]];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: test/tb.sv
// self-checking testbench of the nearest-neighbor image scaler
`timescale 1ns / 1ps
module tb;

  // register index that no register answers to
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // scoreboard: scaler state mirror and queue of expected result transactions
  class scaler_scoreboard;
    logic [23:0] line_mem [4096];
    int unsigned src_w, src_h, factor;
    int unsigned eff_w, eff_h, dst_w, dst_h, w_ratio, h_ratio;
    int unsigned row_loaded, row_in, col_in, row_out, col_out, col_acc, row_acc;
    nnis_pkg::out_t pending_q[$];
    int errors;

    function new();
      src_w = 1;
      src_h = 1;
      factor = 256;
      errors = 0;
      restart();
    endfunction

    function int unsigned scaled(int unsigned n, int unsigned f);
      return (n * f + 127) >> 8;
    endfunction

    function int unsigned ratio(int unsigned s, int unsigned d);
      longint unsigned num;
      num = longint'(s) << 16;
      if (d == 0) return 0;
      return int'((num + d - 1) / d);
    endfunction

    function void restart();
      int unsigned f;
      f = factor > 25600 ? 25600 : factor;
      eff_w = src_w == 0 ? 1 : src_w;
      if (eff_w > 4096) eff_w = 4096;
      eff_h = src_h == 0 ? 1 : src_h;
      if (eff_h > 4096) eff_h = 4096;
      dst_w = scaled(eff_w, f);
      dst_h = scaled(eff_h, f);
      if (dst_w == 0 || dst_h == 0) begin
        dst_w = 0;
        dst_h = 0;
      end
      w_ratio = ratio(eff_w, dst_w);
      h_ratio = ratio(eff_h, dst_h);
      row_loaded = nnis_pkg::NO_ROW;
      row_in = 0;
      col_in = 0;
      row_out = 0;
      col_out = 0;
      col_acc = 0;
      row_acc = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [14:0] val);
      case (idx)
        nnis_pkg::REG_SOURCE_WIDTH: src_w = val[12:0];
        nnis_pkg::REG_SOURCE_HEIGHT: src_h = val[12:0];
        nnis_pkg::REG_SCALE_FACTOR: factor = val;
        default: return;
      endcase
      restart();
    endfunction

    function int unsigned needed_row();
      int unsigned r;
      if (row_out >= dst_h) return eff_h;
      r = row_acc >> 16;
      return r > eff_h - 1 ? eff_h - 1 : r;
    endfunction

    // note an accepted input transaction and predict its result
    function void note_input(nnis_pkg::in_t it);
      nnis_pkg::out_t res;
      int unsigned need, col;
      logic [23:0] px;
      need = needed_row();
      res = '0;
      if (it.operation == nnis_pkg::OP_PIXEL) begin
        if (row_in >= eff_h || row_in > need) begin
          res.status = nnis_pkg::ST_REJECTED;
        end else begin
          if (row_in == need) begin
            if (col_in == 0) row_loaded = nnis_pkg::NO_ROW;
            line_mem[col_in] = {it.red, it.green, it.blue};
            res.status = nnis_pkg::ST_STORED;
          end else begin
            res.status = nnis_pkg::ST_SKIPPED;
          end
          col_in++;
          if (col_in >= eff_w) begin
            if (row_in == need) row_loaded = row_in;
            col_in = 0;
            row_in++;
          end
        end
      end else if (row_out >= dst_h) begin
        res.status = nnis_pkg::ST_DONE;
      end else if (row_loaded != need) begin
        res.status = nnis_pkg::ST_WAIT;
      end else begin
        col = col_acc >> 16;
        if (col > eff_w - 1) col = eff_w - 1;
        px = line_mem[col];
        res.status = nnis_pkg::ST_PIXEL;
        {res.out_red, res.out_green, res.out_blue} = px;
        if (col_out + 1 >= dst_w) begin
          res.last_in_row = 1'b1;
          res.last_in_image = row_out + 1 >= dst_h;
          res.pad_bytes = 2'((4 - ((dst_w * 3) & 3)) & 3);
          col_out = 0;
          col_acc = 0;
          row_out++;
          row_acc += h_ratio;
        end else begin
          col_out++;
          col_acc += w_ratio;
        end
      end
      pending_q.push_back(res);
    endfunction

    task report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    // compare one result transaction with the oldest expectation
    task check_result(nnis_pkg::out_t got);
      nnis_pkg::out_t want;
      if (pending_q.size() == 0) begin
        report("unexpected result", got.status, -1);
        return;
      end
      want = pending_q.pop_front();
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.out_blue !== want.out_blue) report("blue", got.out_blue, want.out_blue);
      if (got.out_green !== want.out_green) report("green", got.out_green, want.out_green);
      if (got.out_red !== want.out_red) report("red", got.out_red, want.out_red);
      if (got.last_in_row !== want.last_in_row)
        report("last_in_row", got.last_in_row, want.last_in_row);
      if (got.last_in_image !== want.last_in_image)
        report("last_in_image", got.last_in_image, want.last_in_image);
      if (got.pad_bytes !== want.pad_bytes) report("pad_bytes", got.pad_bytes, want.pad_bytes);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  nnis_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  nnis_pkg::out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_addr_i = '0;
  logic [14:0] cfg_wdata_i = '0;

  scaler_scoreboard sb = new();
  bit calm_phase = 1'b0;

  nearest_neighbor_image_scaler u_dut (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: random stalls, check each accepted transaction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
    out_ready_i <= calm_phase || ($urandom_range(99) >= 26);
  end

  // one input transaction, with a random gap ahead of it; valid stays high after
  // acceptance until the next gap or the next transaction
  task automatic send_item(nnis_pkg::in_t it);
    while (!calm_phase && $urandom_range(99) < 26) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(it);
  endtask

  task automatic send_pixel();
    nnis_pkg::in_t it;
    it = nnis_pkg::in_t'({nnis_pkg::OP_PIXEL, 24'($urandom())});
    send_item(it);
  endtask

  task automatic send_request();
    nnis_pkg::in_t it;
    it = nnis_pkg::in_t'({nnis_pkg::OP_REQUEST, 24'($urandom())});
    send_item(it);
  endtask

  // drop valid, wait for all results, settle, then write a register
  task automatic write_reg(logic [1:0] idx, logic [14:0] val);
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_geometry(int w, int h, int f);
    write_reg(nnis_pkg::REG_SOURCE_WIDTH, 15'(w));
    write_reg(nnis_pkg::REG_SOURCE_HEIGHT, 15'(h));
    write_reg(nnis_pkg::REG_SCALE_FACTOR, 15'(f));
  endtask

  // well-formed image: rows of pixels, requests in between, some noise
  task automatic run_image(int items);
    for (int n = 0; n < items; n++) begin
      if ($urandom_range(99) < 5) begin
        if ($urandom_range(1)) send_pixel(); else send_request();
      end else if (sb.row_loaded == sb.needed_row() && sb.row_out < sb.dst_h) begin
        send_request();
      end else begin
        send_pixel();
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset geometry, requests before data and after the end
    send_request();
    send_pixel();
    send_request();
    send_request();
    send_pixel();
    send_request();
    // zero-size destination
    set_geometry(3, 2, 0);
    send_request();
    send_pixel();
    // exact half rounds down, padding, overshoot, rejects
    set_geometry(5, 3, 128);
    for (int k = 0; k < 12; k++) send_pixel();
    for (int k = 0; k < 6; k++) send_request();
    // out-of-range registers saturate
    write_reg(nnis_pkg::REG_SOURCE_WIDTH, 15'h1FFF);
    write_reg(nnis_pkg::REG_SOURCE_HEIGHT, 15'h0);
    write_reg(nnis_pkg::REG_SCALE_FACTOR, 15'h7FFF);
    send_request();
    send_pixel();
    write_reg(REG_UNUSED, 15'h5A5A);

    // random images, mostly small, an upscale and a wide row too
    for (int ph = 0; ph < 14; ph++) begin
      int w, h, f;
      calm_phase = (ph == 5);
      w = $urandom_range(1, 7);
      h = $urandom_range(1, 5);
      f = $urandom_range(0, 3) == 0 ? $urandom_range(0, 25600) : $urandom_range(64, 900);
      if (ph == 9) begin
        w = 60;
        h = 8;
        f = 20;
      end
      if (ph == 10) begin
        w = 1;
        h = 1;
        f = 25600;
      end
      set_geometry(w, h, f);
      if (ph == 9) begin
        repeat (61) send_pixel();
        repeat (3) send_request();
      end else if (ph == 10) begin
        run_image(60);
      end else begin
        run_image(26);
      end
    end
    calm_phase = 1'b0;

    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #3ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule

// File: filelist.f
hw/rtl/nnis_pkg.sv
hw/rtl/nnis_div.sv
hw/rtl/nnis_front.sv
hw/rtl/nnis_back.sv
hw/rtl/nearest_neighbor_image_scaler.sv
test/tb.sv
